// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the min-heap priority queue
// Request and status codes, the stored entry layout and the memory command.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned HeapDepthDefault = 256;

  localparam int unsigned IdW    = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 9;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_DECREASE = 2'd2,
    REQ_LOOKUP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // One heap slot: identifier and priority key.
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } entry_t;

  // Command to the heap memory; the address travels alongside.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

// ===== rtl/mhpq_mem.sv =====
// ----------------------------------------------------------------------------
// mhpq_mem: heap entry store
// Single-port synchronous memory, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module mhpq_mem #(
  parameter int unsigned HEAP_DEPTH = mhpq_pkg::HeapDepthDefault,
  parameter int unsigned AddrW      = $clog2(HEAP_DEPTH)
) (
  input  logic               clk_i,
  input  mhpq_pkg::mem_cmd_t cmd_i,
  input  logic [AddrW-1:0]   addr_i,
  input  mhpq_pkg::entry_t   wdata_i,
  output mhpq_pkg::entry_t   rdata_o
);

  mhpq_pkg::entry_t mem_q [HEAP_DEPTH];
  mhpq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap of (id, key) entries
// Insert, delete-minimum, decrease-key and lookup on a memory-held heap.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tuser carries the request kind, tdata
// the id and key. Each request yields exactly one result transaction on the
// master stream, with the status in tuser and the removed or found entry, the
// new minimum and the entry count in tdata.
// One request is worked on at a time. The heap sits in a single-port memory
// with registered read data, so a sift-up level passes through S_SU_CHK and
// S_SU_CMP and a sift-down level through S_SD_CHK, S_SD_L and S_SD_R.
// Decrease-key and lookup walk the heap in preorder, reading and comparing
// each visited entry and climbing back up where needed; a decrease then
// adds its sift-up.
// Every request ends with a read of the root to report the minimum.
// Reset clears the state, the entry count and the output valid; slot contents
// are never used before they are written, so no clearing pass is needed.
// A result waits in an output register while the receiver stalls; the next
// request may be taken meanwhile, and its own result waits until the
// previous transaction has completed.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = mhpq_pkg::HeapDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // item_id[15:0], item_key[47:16]
  input  logic [1:0]   s_axis_tuser,  // req_type[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_id[15:0], out_key[47:16], top_valid[48], top_id[64:49],
  // top_key[96:65], entry_count[105:97], zero fill[111:106]
  output logic [111:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // status[1:0]
);

  localparam int unsigned AddrW = $clog2(HEAP_DEPTH);
  localparam int unsigned CntW  = $clog2(HEAP_DEPTH + 1);
  // Wide enough for the right child index 2*pos+2 of any slot.
  localparam int unsigned WideW = AddrW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SU_CHK, S_SU_CMP, S_DL_ROOT, S_DL_LAST, S_DL_CUR,
    S_SD_CHK, S_SD_L, S_SD_R, S_FD_RD, S_FD_CMP, S_CLIMB, S_FIN, S_FIN_W
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      cnt_q;
  logic [AddrW-1:0]     pos_q;
  logic [AddrW-1:0]     best_idx_q;
  mhpq_pkg::entry_t     cur_q;
  mhpq_pkg::entry_t     best_q;
  mhpq_pkg::req_e       req_q;
  mhpq_pkg::status_e    status_q;
  logic [15:0]          oid_q;
  logic [31:0]          okey_q;

  logic                 out_valid_q;
  mhpq_pkg::status_e    out_status_q;
  logic [15:0]          out_id_q;
  logic [31:0]          out_key_q;
  logic                 top_valid_q;
  logic [15:0]          top_id_q;
  logic [31:0]          top_key_q;
  logic [8:0]           entry_count_q;

  mhpq_pkg::mem_cmd_t   mem_cmd;
  logic [AddrW-1:0]     mem_addr;
  mhpq_pkg::entry_t     mem_wdata;
  mhpq_pkg::entry_t     mem_rdata;

  logic                 in_fire;
  logic                 out_fire;
  logic                 out_load;
  logic [WideW-1:0]     pos_w;
  logic [WideW-1:0]     cnt_w;
  logic [WideW-1:0]     left_w;
  logic [WideW-1:0]     right_w;
  logic                 has_left;
  logic                 has_right;
  logic [AddrW-1:0]     parent;
  logic                 parent_gt;
  logic                 left_lt;
  logic                 right_lt;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  // The finished result moves into the output register once that is free.
  assign out_load = (state_q == S_FIN_W) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE);

  assign pos_w     = WideW'(pos_q);
  assign cnt_w     = WideW'(cnt_q);
  assign left_w    = {pos_w[WideW-2:0], 1'b1};
  assign right_w   = left_w + WideW'(1);
  assign has_left  = left_w < cnt_w;
  assign has_right = right_w < cnt_w;
  assign parent    = (pos_q - AddrW'(1)) >> 1;
  assign parent_gt = mem_rdata.key > cur_q.key;
  assign left_lt   = mem_rdata.key < cur_q.key;
  assign right_lt  = mem_rdata.key < best_q.key;

  // Memory command for the present state.
  always_comb begin
    mem_cmd   = '0;
    mem_addr  = pos_q;
    mem_wdata = cur_q;
    unique case (state_q)
      S_SU_CHK: begin
        if (pos_q == '0) begin
          mem_cmd.wr = 1'b1;
        end else begin
          mem_cmd.rd = 1'b1;
          mem_addr   = parent;
        end
      end
      S_SU_CMP: begin
        mem_cmd.wr = 1'b1;
        if (parent_gt) begin
          mem_wdata = mem_rdata;
        end
      end
      S_DL_ROOT, S_FIN: begin
        mem_cmd.rd = 1'b1;
        mem_addr   = '0;
      end
      S_DL_LAST: begin
        mem_cmd.rd = 1'b1;
        mem_addr   = AddrW'(cnt_q - CntW'(1));
      end
      S_SD_CHK: begin
        if (has_left) begin
          mem_cmd.rd = 1'b1;
          mem_addr   = left_w[AddrW-1:0];
        end else begin
          mem_cmd.wr = 1'b1;
        end
      end
      S_SD_L: begin
        if (has_right) begin
          mem_cmd.rd = 1'b1;
          mem_addr   = right_w[AddrW-1:0];
        end else begin
          mem_cmd.wr = 1'b1;
          if (left_lt) begin
            mem_wdata = mem_rdata;
          end
        end
      end
      S_SD_R: begin
        mem_cmd.wr = 1'b1;
        if (right_lt) begin
          mem_wdata = mem_rdata;
        end else begin
          mem_wdata = best_q;
        end
      end
      S_FD_RD: begin
        mem_cmd.rd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mhpq_mem #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .AddrW      (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q       <= mhpq_pkg::req_e'(s_axis_tuser);
            oid_q       <= s_axis_tdata[15:0];
            okey_q      <= '0;
            cur_q.id    <= s_axis_tdata[15:0];
            cur_q.key   <= s_axis_tdata[47:16];
            unique case (mhpq_pkg::req_e'(s_axis_tuser))
              mhpq_pkg::REQ_INSERT: begin
                if (cnt_q == CntW'(HEAP_DEPTH)) begin
                  status_q <= mhpq_pkg::ST_FULL;
                  state_q  <= S_FIN;
                end else begin
                  status_q <= mhpq_pkg::ST_OK;
                  pos_q    <= AddrW'(cnt_q);
                  cnt_q    <= cnt_q + CntW'(1);
                  state_q  <= S_SU_CHK;
                end
              end
              mhpq_pkg::REQ_DELETE: begin
                if (cnt_q == '0) begin
                  status_q <= mhpq_pkg::ST_EMPTY;
                  state_q  <= S_FIN;
                end else begin
                  status_q <= mhpq_pkg::ST_OK;
                  state_q  <= S_DL_ROOT;
                end
              end
              default: begin
                if (cnt_q == '0) begin
                  status_q <= mhpq_pkg::ST_NOT_FOUND;
                  state_q  <= S_FIN;
                end else begin
                  status_q <= mhpq_pkg::ST_OK;
                  pos_q    <= '0;
                  state_q  <= S_FD_RD;
                end
              end
            endcase
          end
        end
        S_SU_CHK: begin
          state_q <= (pos_q == '0) ? S_FIN : S_SU_CMP;
        end
        S_SU_CMP: begin
          if (parent_gt) begin
            pos_q   <= parent;
            state_q <= S_SU_CHK;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DL_ROOT: begin
          state_q <= S_DL_LAST;
        end
        S_DL_LAST: begin
          // The root leaves; the last slot becomes the entry to sift down.
          oid_q   <= mem_rdata.id;
          okey_q  <= mem_rdata.key;
          cnt_q   <= cnt_q - CntW'(1);
          state_q <= S_DL_CUR;
        end
        S_DL_CUR: begin
          cur_q   <= mem_rdata;
          pos_q   <= '0;
          state_q <= S_SD_CHK;
        end
        S_SD_CHK: begin
          state_q <= has_left ? S_SD_L : S_FIN;
        end
        S_SD_L: begin
          if (has_right) begin
            best_q     <= left_lt ? mem_rdata : cur_q;
            best_idx_q <= left_lt ? left_w[AddrW-1:0] : pos_q;
            state_q    <= S_SD_R;
          end else if (left_lt) begin
            pos_q   <= left_w[AddrW-1:0];
            state_q <= S_SD_CHK;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_SD_R: begin
          if (right_lt) begin
            pos_q   <= right_w[AddrW-1:0];
            state_q <= S_SD_CHK;
          end else if (best_idx_q != pos_q) begin
            pos_q   <= best_idx_q;
            state_q <= S_SD_CHK;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FD_RD: begin
          state_q <= S_FD_CMP;
        end
        S_FD_CMP: begin
          if (mem_rdata.id == oid_q) begin
            if (req_q == mhpq_pkg::REQ_LOOKUP) begin
              okey_q  <= mem_rdata.key;
              state_q <= S_FIN;
            end else begin
              cur_q.id <= mem_rdata.id;
              state_q  <= S_SU_CHK;
            end
          end else if (has_left) begin
            pos_q   <= left_w[AddrW-1:0];
            state_q <= S_FD_RD;
          end else begin
            state_q <= S_CLIMB;
          end
        end
        S_CLIMB: begin
          // Back up the tree until an unvisited right sibling exists.
          if (pos_q == '0) begin
            status_q <= mhpq_pkg::ST_NOT_FOUND;
            state_q  <= S_FIN;
          end else if (pos_q[0] && ((pos_w + WideW'(1)) < cnt_w)) begin
            pos_q   <= pos_q + AddrW'(1);
            state_q <= S_FD_RD;
          end else begin
            pos_q <= parent;
          end
        end
        S_FIN: begin
          state_q <= S_FIN_W;
        end
        S_FIN_W: begin
          if (out_load) begin
            out_status_q  <= status_q;
            out_id_q      <= oid_q;
            out_key_q     <= okey_q;
            top_valid_q   <= (cnt_q != '0);
            top_id_q      <= (cnt_q != '0) ? mem_rdata.id : '0;
            top_key_q     <= (cnt_q != '0) ? mem_rdata.key : '0;
            entry_count_q <= 9'(cnt_q);
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'd0, entry_count_q, top_key_q, top_id_q, top_valid_q,
                          out_key_q, out_id_q};

  // The entry count never exceeds the heap depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(HEAP_DEPTH))
    else $error("entry count beyond heap depth");

  // The memory is left alone while no request is in progress.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!mem_cmd.rd && !mem_cmd.wr))
    else $error("memory access while idle");

  // A reported minimum exists exactly when entries are held.
  a_top_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (top_valid_q == (cnt_q != '0)))
    else $error("top_valid disagrees with entry count");

  // A result held for the receiver is not overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_id_q)
      && $stable(out_key_q) && $stable(top_key_q)))
    else $error("pending result changed");

endmodule
